@@ hdl/mgc_pkg.sv @@
package mgc_pkg;

  localparam int DEPTH_W    = 32;
  localparam int COIN_SIDE  = 7;
  localparam int MASK_W     = COIN_SIDE * COIN_SIDE;
  localparam int RAD_W      = 2;
  localparam int SIZE_W     = 9;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MASK_W;

  // 10000.0 m in Q15.16
  localparam logic signed [DEPTH_W-1:0] START_DEPTH = 32'sd655360000;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODATA = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_MASK   = 3'd2,
    CFG_ROWS   = 3'd3,
    CFG_COLS   = 3'd4
  } cfg_reg_t;

  // Configuration as seen by the engine, sizes and radius already clamped.
  typedef struct packed {
    logic signed [DEPTH_W-1:0] nodata;
    logic [RAD_W-1:0]          radius;
    logic [MASK_W-1:0]         mask;
    logic [COORD_W-1:0]        rows;
    logic [COORD_W-1:0]        cols;
  } cfg_t;

endpackage

@@ hdl/masked_grayscale_closing_top.sv @@
// Masked grayscale closing over a stored depth grid held in one single-port-read
// synchronous memory. A store transaction produces no result. A query
// transaction walks every on-coin offset d of radius R; for each neighbor
// inside the grid it steps through all (2R+1)^2 coin cells and reads each one
// that is on the coin and inside the grid, one memory read per cycle, through
// the single read port of the depth memory. The result waits in an output
// register while the next transaction is accepted. Cells that were never
// stored read back undefined.
module masked_grayscale_closing_top #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_RADIUS = 3
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mgc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mgc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic [7:0]                            row,
  input  logic [7:0]                            col,
  input  logic signed [mgc_pkg::DEPTH_W-1:0]    depth,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mgc_pkg::DEPTH_W-1:0]    smoothed_depth,
  output logic                                  is_nodata
);

  localparam int CW = mgc_pkg::COORD_W;

  logic signed [mgc_pkg::DEPTH_W-1:0] nodata_value;
  logic [mgc_pkg::RAD_W-1:0]          coin_radius;
  logic [mgc_pkg::MASK_W-1:0]         coin_mask;
  logic [mgc_pkg::SIZE_W-1:0]         rows_in_use;
  logic [mgc_pkg::SIZE_W-1:0]         cols_in_use;

  logic [CW-1:0] rows_raw, cols_raw;
  mgc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodata_value <= 32'sh80000000;
      coin_radius  <= 2'd1;
      coin_mask    <= 49'd7575371776;
      rows_in_use  <= 9'd256;
      cols_in_use  <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgc_pkg::CFG_NODATA: nodata_value <= cfg_wdata[mgc_pkg::DEPTH_W-1:0];
        mgc_pkg::CFG_RADIUS: coin_radius  <= cfg_wdata[mgc_pkg::RAD_W-1:0];
        mgc_pkg::CFG_MASK:   coin_mask    <= cfg_wdata[mgc_pkg::MASK_W-1:0];
        mgc_pkg::CFG_ROWS:   rows_in_use  <= cfg_wdata[mgc_pkg::SIZE_W-1:0];
        mgc_pkg::CFG_COLS:   cols_in_use  <= cfg_wdata[mgc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_raw = CW'(rows_in_use);
  assign cols_raw = CW'(cols_in_use);

  // clamp sizes to [1, MAX] and radius to MAX_RADIUS
  always_comb begin
    cfg.nodata = nodata_value;
    cfg.mask   = coin_mask;
    cfg.radius = (coin_radius > mgc_pkg::RAD_W'(MAX_RADIUS)) ?
                 mgc_pkg::RAD_W'(MAX_RADIUS) : coin_radius;
    if (rows_raw == '0) begin
      cfg.rows = CW'(1);
    end else if (rows_raw > CW'(MAX_ROWS)) begin
      cfg.rows = CW'(MAX_ROWS);
    end else begin
      cfg.rows = rows_raw;
    end
    if (cols_raw == '0) begin
      cfg.cols = CW'(1);
    end else if (cols_raw > CW'(MAX_COLS)) begin
      cfg.cols = CW'(MAX_COLS);
    end else begin
      cfg.cols = cols_raw;
    end
  end

  mgc_engine #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .row            (row),
    .col            (col),
    .depth          (depth),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_depth (smoothed_depth),
    .is_nodata      (is_nodata)
  );

endmodule

@@ hdl/mgc_engine.sv @@
module mgc_engine #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mgc_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic [7:0]                           row,
  input  logic [7:0]                           col,
  input  logic signed [mgc_pkg::DEPTH_W-1:0]   depth,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mgc_pkg::DEPTH_W-1:0]   smoothed_depth,
  output logic                                 is_nodata
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW     = mgc_pkg::COORD_W;
  localparam logic [CW-1:0] CTR = CW'(3);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CENTER = 7'b0000010,
    S_OUTER  = 7'b0000100,
    S_INNER  = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_FOLD   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0] q_row;
  logic [7:0] q_col;
  logic       q_inside;
  logic [2:0] oi, oj, ii, ij;
  logic signed [mgc_pkg::DEPTH_W-1:0] result;
  logic signed [mgc_pkg::DEPTH_W-1:0] best;
  logic       found;
  logic       rd_pend;

  logic [mgc_pkg::DEPTH_W-1:0] mem [CELLS];
  logic signed [mgc_pkg::DEPTH_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] c_addr;
  logic [ADDR_W-1:0] n_addr;
  logic [ADDR_W-1:0] raddr;

  logic [2:0]    lo, hi;
  logic          outer_last, inner_last;
  logic [5:0]    outer_bit, inner_bit;
  logic [CW-1:0] s_row, s_col, n_row, n_col;
  logic          s_in, n_in, outer_ok, inner_ok;
  logic          in_inside;
  logic          accept;

  assign lo = 3'd3 - {1'b0, cfg.radius};
  assign hi = 3'd3 + {1'b0, cfg.radius};
  assign outer_last = (oi == hi) && (oj == hi);
  assign inner_last = (ii == hi) && (ij == hi);

  assign outer_bit = 6'({3'b0, oi} * 6'(mgc_pkg::COIN_SIDE) + {3'b0, oj});
  assign inner_bit = 6'({3'b0, ii} * 6'(mgc_pkg::COIN_SIDE) + {3'b0, ij});

  // Neighbor s = p - d, then coin cell n = s + d2
  assign s_row = CW'(q_row) + CTR - CW'(oi);
  assign s_col = CW'(q_col) + CTR - CW'(oj);
  assign n_row = s_row + CW'(ii) - CTR;
  assign n_col = s_col + CW'(ij) - CTR;

  assign s_in = !s_row[CW-1] && (s_row < cfg.rows) && !s_col[CW-1] && (s_col < cfg.cols);
  assign n_in = !n_row[CW-1] && (n_row < cfg.rows) && !n_col[CW-1] && (n_col < cfg.cols);
  assign outer_ok = cfg.mask[outer_bit] && s_in;
  assign inner_ok = cfg.mask[inner_bit] && n_in;

  assign in_inside = (CW'(row) < cfg.rows) && (CW'(col) < cfg.cols);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  assign c_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
  assign n_addr = ADDR_W'(ADDR_W'(n_row) * ADDR_W'(MAX_COLS) + ADDR_W'(n_col));

  assign mem_we = accept && (func == mgc_pkg::FUNC_STORE) && in_inside;
  assign mem_re = (accept && (func == mgc_pkg::FUNC_QUERY)) ||
                  ((state == S_INNER) && inner_ok);
  assign raddr  = (state == S_IDLE) ? c_addr : n_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[c_addr] <= depth;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= (state == S_INNER) && inner_ok;

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // fold the returning coin cell into the running maximum
      if (rd_pend && (rdata != cfg.nodata) && (!found || (rdata > best))) begin
        best  <= rdata;
        found <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (func == mgc_pkg::FUNC_QUERY)) begin
            q_row    <= row;
            q_col    <= col;
            q_inside <= in_inside;
            state    <= S_CENTER;
          end
        end
        S_CENTER: begin
          if (!q_inside || (rdata == cfg.nodata)) begin
            result <= cfg.nodata;
            state  <= S_OUT;
          end else begin
            result <= mgc_pkg::START_DEPTH;
            oi     <= lo;
            oj     <= lo;
            state  <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (outer_ok) begin
            found <= 1'b0;
            ii    <= lo;
            ij    <= lo;
            state <= S_INNER;
          end else if (outer_last) begin
            state <= S_OUT;
          end else if (oj == hi) begin
            oj <= lo;
            oi <= oi + 3'd1;
          end else begin
            oj <= oj + 3'd1;
          end
        end
        S_INNER: begin
          if (inner_last) begin
            state <= S_DRAIN;
          end else if (ij == hi) begin
            ij <= lo;
            ii <= ii + 3'd1;
          end else begin
            ij <= ij + 3'd1;
          end
        end
        S_DRAIN: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          if (found && (best < result)) begin
            result <= best;
          end
          if (outer_last) begin
            state <= S_OUT;
          end else begin
            if (oj == hi) begin
              oj <= lo;
              oi <= oi + 3'd1;
            end else begin
              oj <= oj + 3'd1;
            end
            state <= S_OUTER;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            smoothed_depth <= result;
            is_nodata      <= (result == cfg.nodata);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/mgc_checker.sv @@
module mgc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mgc_pkg::DEPTH_W-1:0]  smoothed_depth,
  input logic                                is_nodata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed_depth) && $stable(is_nodata))
    else $error("result changed while stalled");

  // a query transaction blocks the input side while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == mgc_pkg::FUNC_QUERY) |=> !in_ready)
    else $error("input ready right after a query");

  // a store transaction leaves the input side ready
  a_store_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == mgc_pkg::FUNC_STORE) |=> in_ready)
    else $error("input not ready after a store");

  // a new result only comes out of a running query
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a query in flight");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind masked_grayscale_closing_top mgc_checker u_mgc_checker (.*);
